>>> rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Shader token stream profiler package
// Types, constants and helper functions shared by the profiler modules.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int OPCODE_BINS  = 256;
  localparam int COUNTER_BITS = 32;
  localparam int BIN_W        = $clog2(OPCODE_BINS);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [BIN_W-1:0]        bin_t;

  localparam logic [15:0] VERTEX_TYPE = 16'hFFFE;
  localparam logic [15:0] PIXEL_TYPE  = 16'hFFFF;
  localparam logic [31:0] END_TOKEN   = 32'h0000FFFF;
  localparam logic [15:0] COMMENT_OP  = 16'hFFFE;

  localparam logic CMD_TOKEN  = 1'b0;
  localparam logic CMD_READ   = 1'b1;
  localparam logic RK_SUMMARY = 1'b0;
  localparam logic RK_READ    = 1'b1;

  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_WALK,
    PH_ENDED,
    PH_REJECT
  } phase_e;

  typedef enum logic [2:0] {
    CS_NONE,
    CS_HIST,
    CS_HIGH,
    CS_SHADER,
    CS_INSTR,
    CS_MAL,
    CS_FLOW,
    CS_CLASS
  } csel_e;

  typedef struct packed {
    logic       is_read;
    logic       has_result;
    csel_e      csel;
    logic [1:0] rd_class;
    bin_t       hist_addr;
    logic       inc_bin;
    logic       inc_high;
    logic       inc_instr;
    logic       inc_mal;
    logic       inc_class;
    logic [1:0] cls;
    logic       inc_shader;
    logic       inc_flowsh;
    logic       sum_rej;
    logic [1:0] sum_class;
    logic       sum_flow;
  } op_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    r = (v == '1) ? v : v + cnt_t'(1);
    return r;
  endfunction

  function automatic logic [31:0] clamp_out(input cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic [1:0] classify(input logic [7:0] major, input logic [7:0] minor);
    logic [1:0] c;
    if (major <= 8'd1) begin
      c = 2'd0;
    end else if (major == 8'd2 && minor == 8'd0) begin
      c = 2'd1;
    end else if (major == 8'd2 &&
                 (minor == 8'h0A || minor == 8'h0B || minor >= 8'h80)) begin
      c = 2'd2;
    end else if (major >= 8'd3) begin
      c = 2'd3;
    end else begin
      c = 2'd1;
    end
    return c;
  endfunction

  function automatic logic is_flow(input logic [15:0] op);
    return op == 16'd25 || op == 16'd26 || op == 16'd27 || op == 16'd38 ||
           op == 16'd40 || op == 16'd41 || op == 16'd44 || op == 16'd45 ||
           op == 16'd96;
  endfunction

endpackage

>>> rtl/tsp_if.sv
// ----------------------------------------------------------------------------
// Shader token stream profiler channels
// Valid/ready channels for token and command items and for result items.
// ----------------------------------------------------------------------------
interface tsp_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] token;
  logic        first_word;
  logic        last_word;
  logic [8:0]  counter_index;

  modport source(output valid, command, token, first_word, last_word, counter_index,
                 input ready);
  modport sink(input valid, command, token, first_word, last_word, counter_index,
               output ready);
endinterface

interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        shader_rejected;
  logic [1:0]  model_class;
  logic        used_control_flow;
  logic [31:0] counter_value;

  modport source(output valid, result_kind, shader_rejected, model_class,
                 used_control_flow, counter_value, input ready);
  modport sink(input valid, result_kind, shader_rejected, model_class,
               used_control_flow, counter_value, output ready);
endinterface

>>> rtl/tsp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tsp_front.sv
// ----------------------------------------------------------------------------
// Shader token stream profiler front end
// Walks the token stream, classifies each item and emits one counter op.
// ----------------------------------------------------------------------------
module tsp_front
  import tsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  tsp_in_if.sink   in_i,
  output logic     push_o,
  output op_t      op_o,
  input  logic     full_i
);

  phase_e      phase_q, phase_d;
  logic [14:0] skip_q, skip_d;
  logic        flow_q, flow_d;
  logic [1:0]  class_q, class_d;
  logic        kind_q;

  logic [15:0] op_code;
  logic [15:0] want_type;
  logic        take_tok;
  int          off;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign take_tok   = push_o && (in_i.command == CMD_TOKEN);
  assign op_code    = in_i.token[15:0];
  assign want_type  = kind_q ? PIXEL_TYPE : VERTEX_TYPE;
  assign off        = int'(in_i.counter_index) - OPCODE_BINS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
    end else if (cfg_we_i) begin
      kind_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AWAIT;
      skip_q  <= '0;
      flow_q  <= 1'b0;
      class_q <= '0;
    end else if (take_tok) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      flow_q  <= flow_d;
      class_q <= class_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    flow_d  = flow_q;
    class_d = class_q;
    op_o    = '0;
    op_o.csel = CS_NONE;

    if (in_i.command == CMD_READ) begin
      op_o.is_read    = 1'b1;
      op_o.has_result = 1'b1;
      if (int'(in_i.counter_index) < OPCODE_BINS) begin
        op_o.csel      = CS_HIST;
        op_o.hist_addr = bin_t'(in_i.counter_index);
      end else begin
        unique case (off)
          0:       op_o.csel = CS_HIGH;
          1:       op_o.csel = CS_SHADER;
          2:       op_o.csel = CS_INSTR;
          3:       op_o.csel = CS_MAL;
          4:       op_o.csel = CS_FLOW;
          5, 6, 7, 8: begin
            op_o.csel     = CS_CLASS;
            op_o.rd_class = 2'(off - 5);
          end
          default: op_o.csel = CS_NONE;
        endcase
      end
    end else begin
      if (in_i.first_word || phase_q == PH_AWAIT) begin
        skip_d  = '0;
        flow_d  = 1'b0;
        class_d = '0;
        if (in_i.token[31:16] != want_type) begin
          op_o.inc_mal = 1'b1;
          phase_d      = PH_REJECT;
        end else begin
          class_d        = classify(in_i.token[15:8], in_i.token[7:0]);
          op_o.inc_class = 1'b1;
          op_o.cls       = class_d;
          phase_d        = PH_WALK;
        end
      end else if (phase_q == PH_WALK) begin
        if (skip_q != '0) begin
          skip_d = skip_q - 15'd1;
        end else if (in_i.token == END_TOKEN) begin
          phase_d = PH_ENDED;
        end else if (op_code == COMMENT_OP) begin
          skip_d = in_i.token[30:16];
        end else begin
          if (int'(op_code) < OPCODE_BINS) begin
            op_o.inc_bin   = 1'b1;
            op_o.hist_addr = bin_t'(op_code);
          end else begin
            op_o.inc_high = 1'b1;
          end
          op_o.inc_instr = 1'b1;
          flow_d = flow_q || is_flow(op_code);
          skip_d = 15'(in_i.token[27:24]);
        end
      end

      if (in_i.last_word) begin
        op_o.has_result = 1'b1;
        if (phase_d == PH_REJECT) begin
          op_o.sum_rej = 1'b1;
        end else begin
          op_o.sum_class  = class_d;
          op_o.sum_flow   = flow_d;
          op_o.inc_shader = 1'b1;
          op_o.inc_flowsh = flow_d;
        end
        phase_d = PH_AWAIT;
        skip_d  = '0;
        flow_d  = 1'b0;
        class_d = '0;
      end
    end
  end

endmodule

>>> rtl/tsp_queue.sv
// ----------------------------------------------------------------------------
// Shader token stream profiler op queue
// Short FIFO of counter ops between the front end and the back end.
// ----------------------------------------------------------------------------
module tsp_queue
  import tsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  output logic valid_o,
  output op_t  op_o,
  input  logic pop_i
);

  op_t               buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

>>> rtl/tsp_back.sv
// ----------------------------------------------------------------------------
// Shader token stream profiler back end
// Updates the histogram and totals, answers reads and holds the result item.
// ----------------------------------------------------------------------------
module tsp_back
  import tsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  op_t      q_op_i,
  output logic     pop_o,
  tsp_out_if.source out_o
);

  op_t                    s1_q;
  logic                   s1_valid_q;
  logic                   byp_q;
  cnt_t                   byp_data_q;
  logic [OPCODE_BINS-1:0] hvalid_q;

  cnt_t high_q, shader_q, instr_q, mal_q, flowsh_q;
  cnt_t class_q [4];

  cnt_t rdata;
  cnt_t hist_cur;
  cnt_t hist_new;
  cnt_t rd_val;
  logic out_free;
  logic s1_done;
  logic hist_we;

  logic        out_valid_q;
  logic        out_kind_q;
  logic        out_rej_q;
  logic [1:0]  out_class_q;
  logic        out_flow_q;
  logic [31:0] out_value_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_done  = s1_valid_q && (!s1_q.has_result || out_free);
  assign pop_o    = q_valid_i && (!s1_valid_q || s1_done);
  assign hist_we  = s1_done && s1_q.inc_bin;

  tsp_ram #(
    .WIDTH(COUNTER_BITS),
    .DEPTH(OPCODE_BINS)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(s1_q.hist_addr),
    .wdata_i(hist_new),
    .re_i   (pop_o),
    .raddr_i(q_op_i.hist_addr),
    .rdata_o(rdata)
  );

  always_comb begin
    if (byp_q) begin
      hist_cur = byp_data_q;
    end else if (hvalid_q[s1_q.hist_addr]) begin
      hist_cur = rdata;
    end else begin
      hist_cur = '0;
    end
    hist_new = sat_inc(hist_cur);

    unique case (s1_q.csel)
      CS_HIST:   rd_val = hist_cur;
      CS_HIGH:   rd_val = high_q;
      CS_SHADER: rd_val = shader_q;
      CS_INSTR:  rd_val = instr_q;
      CS_MAL:    rd_val = mal_q;
      CS_FLOW:   rd_val = flowsh_q;
      CS_CLASS:  rd_val = class_q[s1_q.rd_class];
      default:   rd_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else if (pop_o) begin
      s1_valid_q <= 1'b1;
      byp_q      <= hist_we && (s1_q.hist_addr == q_op_i.hist_addr);
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q       <= q_op_i;
      byp_data_q <= hist_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
      high_q   <= '0;
      shader_q <= '0;
      instr_q  <= '0;
      mal_q    <= '0;
      flowsh_q <= '0;
      for (int i = 0; i < 4; i++) begin
        class_q[i] <= '0;
      end
    end else if (s1_done) begin
      if (s1_q.inc_bin) begin
        hvalid_q[s1_q.hist_addr] <= 1'b1;
      end
      if (s1_q.inc_high) begin
        high_q <= sat_inc(high_q);
      end
      if (s1_q.inc_instr) begin
        instr_q <= sat_inc(instr_q);
      end
      if (s1_q.inc_mal) begin
        mal_q <= sat_inc(mal_q);
      end
      if (s1_q.inc_class) begin
        class_q[s1_q.cls] <= sat_inc(class_q[s1_q.cls]);
      end
      if (s1_q.inc_shader) begin
        shader_q <= sat_inc(shader_q);
      end
      if (s1_q.inc_flowsh) begin
        flowsh_q <= sat_inc(flowsh_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_done && s1_q.has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && s1_q.has_result) begin
      out_kind_q  <= s1_q.is_read ? RK_READ : RK_SUMMARY;
      out_rej_q   <= s1_q.sum_rej;
      out_class_q <= s1_q.sum_class;
      out_flow_q  <= s1_q.sum_flow;
      out_value_q <= s1_q.is_read ? clamp_out(rd_val) : 32'd0;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.result_kind       = out_kind_q;
  assign out_o.shader_rejected   = out_rej_q;
  assign out_o.model_class       = out_class_q;
  assign out_o.used_control_flow = out_flow_q;
  assign out_o.counter_value     = out_value_q;

endmodule

>>> rtl/shader_token_stream_profiler.sv
// ----------------------------------------------------------------------------
// Shader token stream profiler
// Walks shader bytecode words, keeps an opcode histogram and shader totals.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle, token word or counter read, while
// the queue is not full; each result item passes through the queue and s1_q into
// a holding output register. While it waits there, the back end stalls at the
// next result item, and the four-entry queue keeps taking items until it fills
// and holds off the input. The rate is set by the histogram memory, read when an
// op leaves the queue and written when it leaves s1_q, with a bypass for repeated
// opcodes. The histogram is cleared at reset through one valid bit per bin, so no
// clearing pass is needed. The user writes the expected shader type through
// cfg_we_i and cfg_wdata_i while the block is idle; the block does not enforce it.
module shader_token_stream_profiler
  import tsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  tsp_in_if.sink    in_i,
  tsp_out_if.source out_o
);

  logic push;
  logic full;
  logic q_valid;
  logic pop;
  op_t  front_op;
  op_t  head_op;

  tsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .push_o     (push),
    .op_o       (front_op),
    .full_i     (full)
  );

  tsp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .full_o (full),
    .valid_o(q_valid),
    .op_o   (head_op),
    .pop_i  (pop)
  );

  tsp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_op_i   (head_op),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
